// ===== hw/rtl/vchp_pkg.sv =====
// shared types and constants of the video chip host port
`default_nettype none

package vchp_pkg;

    localparam int VRAM_BYTES = 16384;
    localparam int REG_COUNT  = 64;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);
    localparam int ADDR_W     = 14;

    localparam logic [2:0] CMD_CTRL_WR   = 3'd0;
    localparam logic [2:0] CMD_DATA_WR   = 3'd1;
    localparam logic [2:0] CMD_DATA_RD   = 3'd2;
    localparam logic [2:0] CMD_STATUS_RD = 3'd3;
    localparam logic [2:0] CMD_STATUS_PK = 3'd4;
    localparam logic [2:0] CMD_VBLANK    = 3'd5;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] bus_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic       reg_written;
        logic [5:0] reg_index;
        logic [7:0] reg_value;
    } rsp_item_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         wdata;
    } vram_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/video_chip_host_port_core.sv =====
// top level of the video chip host port
//
// cmd channel: one bus access or frame-end event per transfer (valid/ready).
// rsp channel: exactly one result per command, in order, from a result register.
// each command's result is registered and is valid the cycle after it is taken.
// data reads and fetching control writes refetch the read-ahead byte through the
// single port of the video memory, whose registered read data lands the next cycle;
// a fetch state copies it to the read-ahead byte, then the next command is taken.
// the command channel also holds while a result waits and the receiver stalls;
// a waiting result and the next command transfer in the same cycle when
// rsp_ready is high.
// reset clears address, latch toggle, read-ahead byte, vblank flag and the
// result register; video memory contents are undefined until written.
`default_nettype none

module video_chip_host_port_core
    import vchp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire cmd_item_t cmd_item,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_item_t      rsp_item
);

    vram_req_t  vram_req;
    logic [7:0] vram_rdata;

    vchp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_item   (cmd_item),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_item   (rsp_item),
        .vram_req   (vram_req),
        .vram_rdata (vram_rdata)
    );

    vchp_vram u_vram (
        .clk   (clk),
        .req   (vram_req),
        .rdata (vram_rdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/vchp_vram.sv =====
// single-port video memory with registered read data
`default_nettype none

module vchp_vram
    import vchp_pkg::*;
(
    input  wire logic      clk,
    input  wire vram_req_t req,
    output logic [7:0]     rdata
);

    logic [7:0] mem [VRAM_BYTES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vchp_ctrl.sv =====
// access sequencer: address, latch toggle, read-ahead, status flag and result register
`default_nettype none

module vchp_ctrl
    import vchp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire cmd_item_t cmd_item,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_item_t      rsp_item,
    output vram_req_t      vram_req,
    input  wire logic [7:0] vram_rdata
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FETCH = 1'b1;

    localparam logic [6:0] REG_LIMIT = 7'(REG_COUNT);

    logic              state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              latch_reg, latch_next;
    logic [7:0]        ahead_reg, ahead_next;
    logic              vblank_reg, vblank_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_item_t         rsp_item_reg, rsp_item_next;

    logic              accept;
    logic [ADDR_W-1:0] hi_addr;
    logic [7:0]        b;

    assign cmd_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = cmd_valid && cmd_ready;
    assign b         = cmd_item.bus_byte;
    assign hi_addr   = {b[5:0], addr_reg[7:0]};
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        latch_next     = latch_reg;
        ahead_next     = ahead_reg;
        vblank_next    = vblank_reg;
        rsp_item_next  = rsp_item_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        vram_req       = '0;

        if (state_reg == ST_FETCH)
        begin
            ahead_next = vram_rdata;
            state_next = ST_IDLE;
        end

        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_item_next  = '0;
            unique case (cmd_item.command)
                CMD_CTRL_WR:
                begin
                    if (latch_reg)
                    begin
                        addr_next  = hi_addr;
                        latch_next = 1'b0;
                        if (b[7] && ({1'b0, b[5:0]} < REG_LIMIT))
                        begin
                            rsp_item_next.reg_written = 1'b1;
                            rsp_item_next.reg_index   = b[5:0];
                            rsp_item_next.reg_value   = addr_reg[7:0];
                        end
                        if (b[7:6] == 2'b00)
                        begin
                            vram_req.re   = 1'b1;
                            vram_req.addr = hi_addr[VRAM_AW-1:0];
                            addr_next     = hi_addr + 1'b1;
                            state_next    = ST_FETCH;
                        end
                    end
                    else
                    begin
                        addr_next  = {addr_reg[ADDR_W-1:8], b};
                        latch_next = 1'b1;
                    end
                end
                CMD_DATA_WR:
                begin
                    vram_req.we    = 1'b1;
                    vram_req.addr  = addr_reg[VRAM_AW-1:0];
                    vram_req.wdata = b;
                    ahead_next     = b;
                    addr_next      = addr_reg + 1'b1;
                    latch_next     = 1'b0;
                end
                CMD_DATA_RD:
                begin
                    rsp_item_next.read_value = ahead_reg;
                    vram_req.re   = 1'b1;
                    vram_req.addr = addr_reg[VRAM_AW-1:0];
                    addr_next     = addr_reg + 1'b1;
                    latch_next    = 1'b0;
                    state_next    = ST_FETCH;
                end
                CMD_STATUS_RD:
                begin
                    rsp_item_next.read_value = {vblank_reg, 7'b0};
                    vblank_next = 1'b0;
                    latch_next  = 1'b0;
                end
                CMD_STATUS_PK:
                begin
                    rsp_item_next.read_value = {vblank_reg, 7'b0};
                end
                CMD_VBLANK:
                begin
                    vblank_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            latch_reg     <= 1'b0;
            ahead_reg     <= '0;
            vblank_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            latch_reg     <= latch_next;
            ahead_reg     <= ahead_next;
            vblank_reg    <= vblank_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_item_reg  <= rsp_item_next;
        end
    end

endmodule

`default_nettype wire
